### rtl/second_order_system_step_macros.svh
// assertion macros shared by the checker of the second order system step
// depends on: a clock and a reset signal in the scope of each use
`ifndef SECOND_ORDER_SYSTEM_STEP_MACROS_SVH
`define SECOND_ORDER_SYSTEM_STEP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SOS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SOS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sos_pkg.sv
// shared types and constants of the second order system step
// no dependencies
package sos_pkg;

   // field widths
   localparam int DATA_W = 32;
   localparam int FREQ_W = 31;
   localparam int TICK_W = 16;
   localparam int FRAC_BITS_DEFAULT = 16;

   // configuration register map
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETPOINT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NAT_FREQ  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DAMPING   = 2'd2;

   // register defaults
   localparam logic [DATA_W-1:0] SETPOINT_RESET = 32'd65536;
   localparam logic [FREQ_W-1:0] NAT_FREQ_RESET = 31'd655360;
   localparam logic [FREQ_W-1:0] DAMPING_RESET  = 31'd65536;

   // shared multiplier: 33 by 33 signed, product register
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SAT_W  = PROD_W + 1;

   // rounded division by 2000: 2000 = 16 * 125, the odd part through a reciprocal
   localparam int    HALF_DT_DIV    = 2000;
   localparam int    DIV_ODD        = 125;
   localparam int    DIV_SHIFT      = $clog2(HALF_DT_DIV / DIV_ODD);
   localparam int    DIV_OFFSET_EXP = 24;
   localparam int    RECIP_SHIFT    = 38;
   localparam int    QUOT_W         = 26;
   localparam int    DIV_SUM_W      = 37;
   localparam longint DIV_RECIP     = (longint'(1) << RECIP_SHIFT) / DIV_ODD;
   localparam longint DIV_BIAS      = HALF_DT_DIV / 2
                                      + longint'(HALF_DT_DIV) * (longint'(1) << DIV_OFFSET_EXP);

   // multiplier operand selection
   typedef enum logic [2:0] {
      MUL_WN_WN,
      MUL_ZETA_WN,
      MUL_WN2_ERR,
      MUL_K_Y,
      MUL_U_RECIP
   } mul_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      logic        load_wn2;
      logic        load_k;
      logic        load_e;
      logic        load_p;
      logic        load_u_e;
      logic        load_u_d;
      logic        acc_r;
      logic        load_d;
      logic        acc_y;
      logic        emit;
   } dp_cmd_type;

endpackage

### rtl/sos_ctrl.sv
// controller state machine of the second order system step
// depends on: sos_pkg
module sos_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                csr_write,
   output logic                csr_ready,
   output sos_pkg::dp_cmd_type cmd
);
   import sos_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_WN2   = 14'b00000000000010,
      ST_ZW    = 14'b00000000000100,
      ST_K     = 14'b00000000001000,
      ST_MUL_E = 14'b00000000010000,
      ST_MUL_P = 14'b00000000100000,
      ST_SUM_E = 14'b00000001000000,
      ST_DIV_E = 14'b00000010000000,
      ST_ACC_R = 14'b00000100000000,
      ST_DER   = 14'b00001000000000,
      ST_SUM_D = 14'b00010000000000,
      ST_DIV_D = 14'b00100000000000,
      ST_ACC_Y = 14'b01000000000000,
      ST_EMIT  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      coef_valid_ff, coef_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // register writes only when idle and no tick is offered in the same cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid = rsp_valid_ff;

   // sequencing of the tick
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_WN_WN;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (coef_valid_ff && !csr_write) ? ST_MUL_E : ST_WN2;
            end
         end
         ST_WN2: begin
            cmd.mul_sel = MUL_WN_WN;
            state_in    = ST_ZW;
         end
         ST_ZW: begin
            cmd.load_wn2 = 1'b1;
            cmd.mul_sel  = MUL_ZETA_WN;
            state_in     = ST_K;
         end
         ST_K: begin
            cmd.load_k = 1'b1;
            state_in   = ST_MUL_E;
         end
         ST_MUL_E: begin
            cmd.mul_sel = MUL_WN2_ERR;
            state_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.load_e  = 1'b1;
            cmd.mul_sel = MUL_K_Y;
            state_in    = ST_SUM_E;
         end
         ST_SUM_E: begin
            cmd.load_p   = 1'b1;
            cmd.load_u_e = 1'b1;
            state_in     = ST_DIV_E;
         end
         ST_DIV_E: begin
            cmd.mul_sel = MUL_U_RECIP;
            state_in    = ST_ACC_R;
         end
         ST_ACC_R: begin
            cmd.acc_r = 1'b1;
            state_in  = ST_DER;
         end
         ST_DER: begin
            cmd.load_d = 1'b1;
            state_in   = ST_SUM_D;
         end
         ST_SUM_D: begin
            cmd.load_u_d = 1'b1;
            state_in     = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.mul_sel = MUL_U_RECIP;
            state_in    = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            cmd.acc_y = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // coefficient cache flag and output valid
   always_comb begin
      coef_valid_in = coef_valid_ff;
      if (csr_write) begin
         coef_valid_in = 1'b0;
      end else if (state_ff == ST_K) begin
         coef_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         coef_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         coef_valid_ff <= coef_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

### rtl/sos_datapath.sv
// datapath of the second order system step: registers, shared multiplier,
// rounding, saturation and the reciprocal division by 2000; depends on: sos_pkg
module sos_datapath #(
   parameter int FRAC_BITS = sos_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sos_pkg::dp_cmd_type                  cmd,
   input  logic                                 req_restart,
   input  logic                                 csr_write,
   input  logic [sos_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sos_pkg::DATA_W-1:0]           csr_data,
   output logic signed [sos_pkg::DATA_W-1:0]    rsp_response,
   output logic [sos_pkg::TICK_W-1:0]           rsp_tick_index
);
   import sos_pkg::*;

   localparam logic [SAT_W-1:0]     ROUND_HALF = SAT_W'(1) << (FRAC_BITS - 1);
   localparam logic [SAT_W-1:0]     DIV_OFFSET = SAT_W'(1) << DIV_OFFSET_EXP;
   localparam logic [DIV_SUM_W-1:0] DIV_BIAS_C = DIV_SUM_W'(DIV_BIAS);
   localparam logic [MUL_W-1:0]     RECIP_C    = MUL_W'(DIV_RECIP);

   // clamp a wide two's complement value to the 32-bit signed range
   function automatic logic [DATA_W-1:0] sat32(input logic [SAT_W-1:0] v);
      logic fits;
      fits = (&v[SAT_W-1:DATA_W-1]) | (~|v[SAT_W-1:DATA_W-1]);
      if (fits) begin
         return v[DATA_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [SAT_W-1:0] sext(input logic [DATA_W-1:0] v);
      return {{(SAT_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   // configuration registers
   logic [DATA_W-1:0] sp_ff, sp_in;
   logic [FREQ_W-1:0] wn_ff, wn_in;
   logic [FREQ_W-1:0] zeta_ff, zeta_in;
   // plant state
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] eprev_ff, eprev_in;
   logic [DATA_W-1:0] dprev_ff, dprev_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   // working registers
   logic [DATA_W-1:0] wn2_ff, wn2_in;
   logic [DATA_W-1:0] k_ff, k_in;
   logic [DATA_W-1:0] err_ff, err_in;
   logic [DATA_W-1:0] e_ff, e_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic [DATA_W-1:0] d_ff, d_in;
   logic [DATA_W-1:0] u_ff, u_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] rsp_response_ff, rsp_response_in;
   logic [TICK_W-1:0] rsp_tick_ff, rsp_tick_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [SAT_W-1:0]  scale_sum, scaled_wide;
   logic [DATA_W-1:0]        scaled;
   logic [DATA_W-1:0]        y_eff;
   logic [DIV_SUM_W-1:0]     div_sum;
   logic [DATA_W-1:0]        div_a, div_b;
   logic [QUOT_W-1:0]        qhat;
   logic [MUL_W-1:0]         qhat_x, rem;
   logic                     corr;
   logic [DATA_W-1:0]        acc_base;
   logic [SAT_W-1:0]         acc_wide;
   logic [DATA_W-1:0]        acc_sat;

   assign rsp_response   = rsp_response_ff;
   assign rsp_tick_index = rsp_tick_ff;

   // shared multiplier operand selection
   always_comb begin
      case (cmd.mul_sel)
         MUL_WN_WN: begin
            mul_a = {2'b00, wn_ff};
            mul_b = {2'b00, wn_ff};
         end
         MUL_ZETA_WN: begin
            mul_a = {2'b00, zeta_ff};
            mul_b = {2'b00, wn_ff};
         end
         MUL_WN2_ERR: begin
            mul_a = {wn2_ff[DATA_W-1], wn2_ff};
            mul_b = {err_ff[DATA_W-1], err_ff};
         end
         MUL_K_Y: begin
            mul_a = {k_ff[DATA_W-1], k_ff};
            mul_b = {y_ff[DATA_W-1], y_ff};
         end
         MUL_U_RECIP: begin
            mul_a = {1'b0, u_ff};
            mul_b = RECIP_C;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // product back to fixed point, nearest with ties upward, then clamped
   always_comb begin
      scale_sum   = {prod_ff[PROD_W-1], prod_ff} + ROUND_HALF;
      scaled_wide = scale_sum >>> FRAC_BITS;
      scaled      = sat32(scaled_wide);
   end

   // biased sum for the division: ((a + b + 1000) >>> 4) + 125 * 2^24
   always_comb begin
      div_a   = cmd.load_u_d ? d_ff : e_ff;
      div_b   = cmd.load_u_d ? dprev_ff : eprev_ff;
      div_sum = {{(DIV_SUM_W-DATA_W){div_a[DATA_W-1]}}, div_a}
              + {{(DIV_SUM_W-DATA_W){div_b[DATA_W-1]}}, div_b}
              + DIV_BIAS_C;
   end

   // reciprocal quotient with one correction step, then accumulate
   always_comb begin
      qhat     = prod_ff[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      qhat_x   = MUL_W'(qhat) * MUL_W'(DIV_ODD);
      rem      = {1'b0, u_ff} - qhat_x;
      corr     = (rem >= MUL_W'(DIV_ODD));
      acc_base = cmd.acc_y ? y_ff : r_ff;
      acc_wide = sext(acc_base) + {{(SAT_W-QUOT_W){1'b0}}, qhat}
               + {{(SAT_W-1){1'b0}}, corr} - DIV_OFFSET;
      acc_sat  = sat32(acc_wide);
   end

   // next values of all registers
   always_comb begin
      sp_in           = sp_ff;
      wn_in           = wn_ff;
      zeta_in         = zeta_ff;
      r_in            = r_ff;
      eprev_in        = eprev_ff;
      dprev_in        = dprev_ff;
      y_in            = y_ff;
      tick_in         = tick_ff;
      wn2_in          = wn2_ff;
      k_in            = k_ff;
      err_in          = err_ff;
      e_in            = e_ff;
      p_in            = p_ff;
      d_in            = d_ff;
      u_in            = u_ff;
      rsp_response_in = rsp_response_ff;
      rsp_tick_in     = rsp_tick_ff;
      y_eff           = req_restart ? '0 : y_ff;

      // configuration writes, unknown indexes ignored
      if (csr_write) begin
         case (csr_index)
            CSR_SETPOINT: sp_in   = csr_data;
            CSR_NAT_FREQ: wn_in   = csr_data[FREQ_W-1:0];
            CSR_DAMPING:  zeta_in = csr_data[FREQ_W-1:0];
            default:      sp_in   = sp_ff;
         endcase
      end

      // start of a tick, with optional restart of the plant state
      if (cmd.accept) begin
         err_in = sat32(sext(sp_ff) - sext(y_eff));
         if (req_restart) begin
            r_in     = '0;
            eprev_in = '0;
            dprev_in = '0;
            y_in     = '0;
            tick_in  = '0;
         end
      end

      if (cmd.load_wn2) wn2_in = scaled;
      if (cmd.load_k)   k_in   = sat32(sext(scaled) << 1);
      if (cmd.load_e)   e_in   = scaled;
      if (cmd.load_p)   p_in   = scaled;
      if (cmd.load_u_e || cmd.load_u_d) begin
         u_in = div_sum[DIV_SHIFT+DATA_W-1:DIV_SHIFT];
      end
      if (cmd.acc_r) begin
         r_in     = acc_sat;
         eprev_in = e_ff;
      end
      if (cmd.load_d) d_in = sat32(sext(r_ff) - sext(p_ff));
      if (cmd.acc_y) begin
         y_in     = acc_sat;
         dprev_in = d_ff;
      end

      // result transaction into the output register
      if (cmd.emit) begin
         rsp_response_in = y_ff;
         rsp_tick_in     = tick_ff;
         tick_in         = tick_ff + TICK_W'(1);
      end
   end

   // configuration and plant state
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= SETPOINT_RESET;
         wn_ff    <= NAT_FREQ_RESET;
         zeta_ff  <= DAMPING_RESET;
         r_ff     <= '0;
         eprev_ff <= '0;
         dprev_ff <= '0;
         y_ff     <= '0;
         tick_ff  <= '0;
      end else begin
         sp_ff    <= sp_in;
         wn_ff    <= wn_in;
         zeta_ff  <= zeta_in;
         r_ff     <= r_in;
         eprev_ff <= eprev_in;
         dprev_ff <= dprev_in;
         y_ff     <= y_in;
         tick_ff  <= tick_in;
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      wn2_ff          <= wn2_in;
      k_ff            <= k_in;
      err_ff          <= err_in;
      e_ff            <= e_in;
      p_ff            <= p_in;
      d_ff            <= d_in;
      u_ff            <= u_in;
      prod_ff         <= prod_in;
      rsp_response_ff <= rsp_response_in;
      rsp_tick_ff     <= rsp_tick_in;
   end

endmodule

### rtl/second_order_system_step.sv
// A result is shown after its input transaction has passed the controller states; for the first
// one after reset or a register write the wn^2 and 2*zeta*wn coefficients are rebuilt first.
// One transaction is handled at a time: a new one is taken only when idle, as the
// single shared multiplier walks the dependent products and the two divisions by 2000.
// Reset (synchronous): registers to defaults, integrator state, tick count, valid cleared.
module second_order_system_step #(
   parameter int FRAC_BITS = sos_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sos_pkg::DATA_W-1:0]   rsp_response,
   output logic [sos_pkg::TICK_W-1:0]          rsp_tick_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sos_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sos_pkg::DATA_W-1:0]          csr_data
);
   import sos_pkg::*;

   dp_cmd_type cmd;
   logic       csr_write;

   // register write transaction
   assign csr_write = csr_valid && csr_ready;

   sos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_write (csr_write),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   sos_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_restart    (req_restart),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_response   (rsp_response),
      .rsp_tick_index (rsp_tick_index)
   );

endmodule

### rtl/sos_checker.sv
// port level checks of the second order system step, bound to the top level
// depends on: second_order_system_step_macros.svh, sos_pkg
`include "second_order_system_step_macros.svh"

module sos_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [sos_pkg::DATA_W-1:0] rsp_response,
   input logic [sos_pkg::TICK_W-1:0]        rsp_tick_index
);
   import sos_pkg::*;

   logic       in_take, out_take;
   logic [1:0] pending_ff, pending_in;

   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;

   // transactions taken but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (in_take && !out_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (out_take && !in_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `SOS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_response) && $stable(rsp_tick_index), "stalled result changed")
   `SOS_ASSERT_SAME(a_no_extra_rsp, out_take, pending_ff != 2'd0, "result without a pending transaction")
   `SOS_ASSERT_SAME(a_two_max, pending_ff == 2'd2, req_stall, "third transaction could be taken")
   `SOS_ASSERT_NEXT(a_busy_after_take, in_take, req_stall, "not busy after taking a transaction")

endmodule

bind second_order_system_step sos_checker u_checker (.*);
